@@ hw/rtl/sfp_pkg.sv @@
// shared types and constants for the starfield perspective plotter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sfp_pkg;
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam logic [1:0] GLYPH_BRIGHT = 2'd0;
    localparam logic [1:0] GLYPH_DIM    = 2'd1;
    localparam logic [1:0] GLYPH_TRAIL  = 2'd2;

    localparam logic [0:0] REG_SPEED = 1'd0;
    localparam logic [0:0] REG_ZOOM  = 1'd1;

    localparam int SPAWN_DEPTH  = 600;
    localparam int BRIGHT_LIMIT = 200;
    localparam int TRAIL_LIMIT  = 300;
    localparam int TRAIL_OFFSET = 40;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        idx;
        logic signed [9:0] px;
        logic signed [9:0] py;
        logic [9:0]        dep;
        logic [5:0]        color;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_UPD, S_DIVC, S_DIVR, S_CHK, S_EMIT1,
        S_TRAIL, S_TDIVC, S_TDIVR, S_TCHK, S_TREAD, S_EMIT2, S_CLEAR
    } t_state;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} t_dstate;
endpackage
`default_nettype wire

@@ hw/rtl/sfp_divider.sv @@
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// uses sfp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfp_divider (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [31:0] i_num,
    input  wire        [11:0] i_den,
    output logic              o_done,
    output logic signed [31:0] o_quot
);
    sfp_pkg::t_dstate r_st, n_st;
    logic [31:0] r_rem, r_q, r_mag;
    logic [11:0] r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [32:0] w_try;
    logic [31:0] w_rs;

    assign w_rs  = {r_rem[30:0], r_mag[r_cnt]};
    assign w_try = {1'b0, w_rs} - {21'd0, r_den};

    always_comb begin
        n_st = r_st;
        case (r_st)
            sfp_pkg::D_IDLE: if (i_start) n_st = sfp_pkg::D_RUN;
            sfp_pkg::D_RUN:  if (r_cnt == 5'd0) n_st = sfp_pkg::D_DONE;
            sfp_pkg::D_DONE: n_st = sfp_pkg::D_IDLE;
            default:         n_st = sfp_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= sfp_pkg::D_IDLE;
        else r_st <= n_st;
        if (r_st == sfp_pkg::D_IDLE && i_start) begin
            r_mag <= i_num[31] ? 32'(-i_num) : i_num;
            r_neg <= i_num[31];
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= 5'd31;
        end else if (r_st == sfp_pkg::D_RUN) begin
            if (!w_try[32]) begin
                r_rem <= w_try[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_rs;
                r_q   <= {r_q[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = (r_st == sfp_pkg::D_DONE);
    assign o_quot = r_neg ? 32'(-r_q) : r_q;
endmodule
`default_nettype wire

@@ hw/rtl/sfp_front.sv @@
// front end: accepts requests, drops ignored kinds and out-of-range star indices, queues the rest
// uses sfp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfp_front #(
    parameter int STAR_COUNT = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire sfp_pkg::t_req i_req,
    output logic             o_valid,
    input  wire              i_ready,
    output sfp_pkg::t_req    o_req
);
    localparam int QD = 4;
    sfp_pkg::t_req r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic w_push, w_pop, w_keep;

    assign w_keep = (i_req.kind == sfp_pkg::KIND_CLEAR) ||
                    ((i_req.kind == sfp_pkg::KIND_LOAD ||
                      i_req.kind == sfp_pkg::KIND_ADVANCE) &&
                     ({24'd0, i_req.idx} < 32'(STAR_COUNT)));
    assign o_ready = (r_cnt != 3'(QD));
    assign w_push  = i_valid && o_ready && w_keep;
    assign o_valid = (r_cnt != 3'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
        if (w_push) r_q[r_wp] <= i_req;
    end
endmodule
`default_nettype wire

@@ hw/rtl/sfp_back.sv @@
// back end: star table, occupancy map, projection sequencer
// uses sfp_pkg, sfp_divider
`timescale 1ns / 1ps
`default_nettype none
module sfp_back #(
    parameter int STAR_COUNT    = 256,
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire sfp_pkg::t_req i_req,
    input  wire       [9:0]  i_speed,
    input  wire       [9:0]  i_zoom,
    output logic             o_valid,
    input  wire              i_ready,
    output logic      [4:0]  o_row,
    output logic      [6:0]  o_col,
    output logic      [1:0]  o_glyph,
    output logic      [5:0]  o_color_out,
    output logic             o_last
);
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CW = $clog2(CELLS);
    localparam int SW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    logic [35:0] r_tab [STAR_COUNT];
    logic        r_map [CELLS];
    logic [35:0] r_rd;
    logic        r_mrd;

    sfp_pkg::t_state r_st, n_st;
    sfp_pkg::t_req   r_req;
    logic signed [9:0] r_x, r_y;
    logic [5:0]  r_c;
    logic [9:0]  r_z;
    logic [11:0] r_zd;
    logic signed [31:0] r_col, r_row;
    logic [CW-1:0] r_clr, r_tidx;
    logic [4:0]  r_orow, r_hrow;
    logic [6:0]  r_ocol, r_hcol;
    logic [1:0]  r_og;
    logic [5:0]  r_oc;
    logic        r_ol, r_ov;
    logic        r_dstart;
    logic signed [31:0] r_num;
    logic [11:0] r_den;
    logic        w_done;
    logic signed [31:0] w_quot;
    logic signed [11:0] w_zn;
    logic        w_on;
    logic        w_ofree;
    logic [CW-1:0] w_cell;

    sfp_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quot(w_quot)
    );

    assign w_zn = $signed({2'b00, r_rd[15:6]}) - $signed({2'b00, i_speed});
    assign w_on = (r_col >= 0) && (r_col < 32'(SCREEN_WIDTH)) &&
                  (r_row >= 0) && (r_row < 32'(SCREEN_HEIGHT));
    assign w_cell = CW'(r_row * 32'(SCREEN_WIDTH) + r_col);
    assign w_ofree = !r_ov || i_ready;

    always_comb begin
        n_st = r_st;
        case (r_st)
            sfp_pkg::S_IDLE: if (i_valid) begin
                if (i_req.kind == sfp_pkg::KIND_CLEAR) n_st = sfp_pkg::S_CLEAR;
                else if (i_req.kind == sfp_pkg::KIND_ADVANCE) n_st = sfp_pkg::S_READ;
            end
            sfp_pkg::S_READ:  n_st = sfp_pkg::S_UPD;
            sfp_pkg::S_UPD:   n_st = sfp_pkg::S_DIVC;
            sfp_pkg::S_DIVC:  if (w_done) n_st = sfp_pkg::S_DIVR;
            sfp_pkg::S_DIVR:  if (w_done) n_st = sfp_pkg::S_CHK;
            sfp_pkg::S_CHK: begin
                if (!w_on) n_st = sfp_pkg::S_IDLE;
                else if (r_z < 10'(sfp_pkg::TRAIL_LIMIT)) n_st = sfp_pkg::S_TRAIL;
                else n_st = sfp_pkg::S_EMIT1;
            end
            sfp_pkg::S_EMIT1: if (w_ofree) n_st = r_mrd ? sfp_pkg::S_IDLE : sfp_pkg::S_EMIT2;
            sfp_pkg::S_TRAIL: n_st = sfp_pkg::S_TDIVC;
            sfp_pkg::S_TDIVC: if (w_done) n_st = sfp_pkg::S_TDIVR;
            sfp_pkg::S_TDIVR: if (w_done) n_st = sfp_pkg::S_TCHK;
            sfp_pkg::S_TCHK:  n_st = sfp_pkg::S_TREAD;
            sfp_pkg::S_TREAD: n_st = sfp_pkg::S_EMIT1;
            sfp_pkg::S_EMIT2: if (w_ofree) n_st = sfp_pkg::S_IDLE;
            sfp_pkg::S_CLEAR: if (r_clr == CW'(CELLS - 1)) n_st = sfp_pkg::S_IDLE;
            default:          n_st = sfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == sfp_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= sfp_pkg::S_CLEAR;
            r_clr <= '0;
            r_ov <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_st <= n_st;
            r_dstart <= 1'b0;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                sfp_pkg::S_IDLE: begin
                    r_clr <= '0;
                    if (i_valid) r_req <= i_req;
                    if (i_valid && i_req.kind == sfp_pkg::KIND_LOAD)
                        r_tab[SW'(i_req.idx)] <= {i_req.px, i_req.py, i_req.dep, i_req.color};
                end
                sfp_pkg::S_READ: r_rd <= r_tab[SW'(r_req.idx)];
                sfp_pkg::S_UPD: begin
                    if (w_zn < 12'sd1) begin
                        r_x <= r_req.px; r_y <= r_req.py; r_c <= r_req.color;
                        r_z <= 10'(sfp_pkg::SPAWN_DEPTH);
                        r_zd <= 12'(sfp_pkg::SPAWN_DEPTH);
                        r_tab[SW'(r_req.idx)] <= {r_req.px, r_req.py,
                            10'(sfp_pkg::SPAWN_DEPTH), r_req.color};
                        r_num <= 32'(r_req.px) * $signed({22'd0, i_zoom}) +
                                 32'(SCREEN_WIDTH / 2) * 32'(sfp_pkg::SPAWN_DEPTH);
                        r_den <= 12'(sfp_pkg::SPAWN_DEPTH);
                    end else begin
                        r_x <= r_rd[35:26]; r_y <= r_rd[25:16]; r_c <= r_rd[5:0];
                        r_z <= w_zn[9:0];
                        r_zd <= {2'b00, w_zn[9:0]};
                        r_tab[SW'(r_req.idx)] <= {r_rd[35:16], w_zn[9:0], r_rd[5:0]};
                        r_num <= 32'($signed(r_rd[35:26])) * $signed({22'd0, i_zoom}) +
                                 32'(SCREEN_WIDTH / 2) * $signed({20'd0, w_zn});
                        r_den <= {2'b00, w_zn[9:0]};
                    end
                    r_dstart <= 1'b1;
                end
                sfp_pkg::S_DIVC, sfp_pkg::S_TDIVC: if (w_done) begin
                    r_col <= w_quot;
                    r_num <= 32'(r_y) * $signed({22'd0, i_zoom}) +
                             32'(2 * (SCREEN_HEIGHT / 2)) * $signed({20'd0, r_zd});
                    r_den <= {r_zd[10:0], 1'b0};
                    r_dstart <= 1'b1;
                end
                sfp_pkg::S_DIVR, sfp_pkg::S_TDIVR: if (w_done) r_row <= w_quot;
                sfp_pkg::S_CHK: begin
                    r_mrd <= 1'b1;
                    if (w_on) begin
                        r_map[w_cell] <= 1'b1;
                        r_hrow <= r_row[4:0]; r_hcol <= r_col[6:0];
                    end
                end
                sfp_pkg::S_EMIT1: if (w_ofree) begin
                    r_orow <= r_hrow; r_ocol <= r_hcol;
                    r_og <= (r_z < 10'(sfp_pkg::BRIGHT_LIMIT)) ?
                            sfp_pkg::GLYPH_BRIGHT : sfp_pkg::GLYPH_DIM;
                    r_oc <= r_c;
                    r_ol <= r_mrd;
                    r_ov <= 1'b1;
                end
                sfp_pkg::S_TRAIL: begin
                    r_zd <= {2'b00, r_z} + 12'(sfp_pkg::TRAIL_OFFSET);
                    r_num <= 32'(r_x) * $signed({22'd0, i_zoom}) +
                             32'(SCREEN_WIDTH / 2) *
                             $signed({22'd0, r_z} + 32'(sfp_pkg::TRAIL_OFFSET));
                    r_den <= {2'b00, r_z} + 12'(sfp_pkg::TRAIL_OFFSET);
                    r_dstart <= 1'b1;
                end
                sfp_pkg::S_TCHK: begin
                    r_tidx <= w_cell;
                    r_mrd <= w_on ? r_map[w_cell] : 1'b1;
                end
                sfp_pkg::S_TREAD: ;
                sfp_pkg::S_EMIT2: if (w_ofree) begin
                    r_map[r_tidx] <= 1'b1;
                    r_orow <= r_row[4:0]; r_ocol <= r_col[6:0];
                    r_og <= sfp_pkg::GLYPH_TRAIL;
                    r_oc <= r_c;
                    r_ol <= 1'b1;
                    r_ov <= 1'b1;
                end
                sfp_pkg::S_CLEAR: begin
                    r_map[r_clr] <= 1'b0;
                    r_clr <= r_clr + CW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_ov;
    assign o_row       = r_orow;
    assign o_col       = r_ocol;
    assign o_glyph     = r_og;
    assign o_color_out = r_oc;
    assign o_last      = r_ol;
endmodule
`default_nettype wire

@@ hw/rtl/starfield_perspective_plotter.sv @@
// top level: config registers, front queue and back sequencer
// uses sfp_pkg, sfp_front, sfp_back
// advance: a first plot follows the request if the star is on screen; when a trail is checked,
// a trail plot follows it if its cell is free; two or four divisions on the shared divider, one request at a time
// back end busy for each request in turn: advance, load, or clear of SCREEN_WIDTH*SCREEN_HEIGHT cells
// after reset the map's SCREEN_WIDTH*SCREEN_HEIGHT cells are cleared before requests run
`timescale 1ns / 1ps
`default_nettype none
module starfield_perspective_plotter #(
    parameter int STAR_COUNT    = 256,
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire       [1:0]  i_kind,
    input  wire       [7:0]  i_star_index,
    input  wire signed [9:0] i_pos_x,
    input  wire signed [9:0] i_pos_y,
    input  wire       [9:0]  i_depth,
    input  wire       [5:0]  i_color,
    output logic             o_valid,
    input  wire              i_ready,
    output logic      [4:0]  o_row,
    output logic      [6:0]  o_col,
    output logic      [1:0]  o_glyph,
    output logic      [5:0]  o_color_out,
    output logic             o_last,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire       [0:0]  i_cfg_index,
    input  wire       [9:0]  i_cfg_data
);
    logic [9:0] r_speed, r_zoom;
    sfp_pkg::t_req w_in, w_q;
    logic w_qv, w_qr;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 10'd10;
            r_zoom  <= 10'd100;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sfp_pkg::REG_SPEED) r_speed <= i_cfg_data;
            else r_zoom <= i_cfg_data;
        end
    end

    assign w_in = '{kind: i_kind, idx: i_star_index, px: i_pos_x, py: i_pos_y,
                    dep: i_depth, color: i_color};

    sfp_front #(.STAR_COUNT(STAR_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    sfp_back #(.STAR_COUNT(STAR_COUNT), .SCREEN_WIDTH(SCREEN_WIDTH),
               .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_req(w_q), .i_speed(r_speed), .i_zoom(r_zoom),
        .o_valid(o_valid), .i_ready(i_ready), .o_row(o_row), .o_col(o_col),
        .o_glyph(o_glyph), .o_color_out(o_color_out), .o_last(o_last)
    );
endmodule
`default_nettype wire
